/* rtl/aob_pkg.sv */
// ============================================================================
// aob_pkg
// Shared types and constants for the ARGB8888 source-over blend pipeline.
// ============================================================================
package aob_pkg;

	localparam logic [7:0] FULL_ALPHA = 8'd255;

	// Divider stages, two quotient bits each, for an 8-bit quotient
	localparam int DIV_STAGES = 4;

	// Numerator bound: 255 * 65025 < 2^24
	localparam int NUM_W = 24;
	// Divisor pre-shifted for the first quotient bit pair: 16 + 6 bits
	localparam int DS_SH = 2 * (DIV_STAGES - 1);
	localparam int DS_W  = 16 + DS_SH;

	typedef enum logic [1:0] {
		PATH_PASS   = 2'd0,
		PATH_TRANS  = 2'd1,
		PATH_OPAQUE = 2'd2
	} path_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pix_t;

	// lane 0 red, lane 1 green, lane 2 blue
	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		rgb_t        cb;
		rgb_t        co;
		logic [7:0]  ao;
		logic [15:0] w;
		logic [15:0] v;
		logic [15:0] d;
		path_t       path;
	} wgt_t;

	typedef struct packed {
		rgb_t                        co;
		logic [7:0]                  ao;
		logic [7:0]                  alpha;
		logic                        dz;
		logic [DS_W-1:0]             ds;
		logic [2:0][NUM_W-1:0]       rem;
		rgb_t                        quo;
		path_t                       path;
	} div_t;

	typedef struct packed {
		logic [7:0] alpha;
		rgb_t       c;
		path_t      path;
	} res_t;

endpackage

/* rtl/argb_over_blend.sv */
// ============================================================================
// argb_over_blend
// Source-over blend of an ARGB8888 overlay pixel onto an ARGB8888 base pixel.
//
// Input channel: in_valid/in_ready with the base and overlay fields; one
// transfer per pixel pair. Output channel: out_valid/out_ready with the
// blended pixel and blend_path (pass-through, translucent, opaque base).
// Seven register stages: weights, numerators, four divider stages of two
// quotient bits each, result select. out_valid rises once the pixel has
// passed all seven registers; throughput is one pixel per cycle, limited
// by nothing but the output side.
// Each stage has its own valid bit and takes a new pixel whenever it is
// empty or its successor takes its content, so bubbles close up while
// the receiver stalls and no transfer is lost or repeated. in_ready drops
// only when every stage holds a pixel and out_ready is low.
// Reset clears all valid bits; the block accepts input right after.
// ============================================================================
module argb_over_blend import aob_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] base_alpha,
	input  logic [7:0] base_red,
	input  logic [7:0] base_green,
	input  logic [7:0] base_blue,
	input  logic [7:0] overlay_alpha,
	input  logic [7:0] overlay_red,
	input  logic [7:0] overlay_green,
	input  logic [7:0] overlay_blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_alpha,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic [1:0] blend_path
);

	pix_t base;
	pix_t over;

	logic w_valid;
	logic w_ready;
	wgt_t w_data;

	logic [DIV_STAGES:0] d_valid;
	logic [DIV_STAGES:0] d_ready;
	div_t                d_data [DIV_STAGES+1];

	res_t res;

	assign base = '{a: base_alpha, r: base_red, g: base_green, b: base_blue};
	assign over = '{a: overlay_alpha, r: overlay_red, g: overlay_green, b: overlay_blue};

	aob_weight u_weight (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.base     (base),
		.over     (over),
		.dn_valid (w_valid),
		.dn_ready (w_ready),
		.dn_data  (w_data)
	);

	aob_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (w_valid),
		.up_ready (w_ready),
		.up_data  (w_data),
		.dn_valid (d_valid[0]),
		.dn_ready (d_ready[0]),
		.dn_data  (d_data[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		aob_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (d_valid[k]),
			.up_ready (d_ready[k]),
			.up_data  (d_data[k]),
			.dn_valid (d_valid[k+1]),
			.dn_ready (d_ready[k+1]),
			.dn_data  (d_data[k+1])
		);
	end

	aob_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (d_valid[DIV_STAGES]),
		.up_ready (d_ready[DIV_STAGES]),
		.up_data  (d_data[DIV_STAGES]),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_data  (res)
	);

	assign out_alpha  = res.alpha;
	assign out_red    = res.c[0];
	assign out_green  = res.c[1];
	assign out_blue   = res.c[2];
	assign blend_path = res.path;

endmodule

/* rtl/aob_weight.sv */
// ============================================================================
// aob_weight
// Stage 1: blend class, channel weights and the combined-alpha divisor.
// ============================================================================
module aob_weight import aob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  pix_t base,
	input  pix_t over,
	output logic dn_valid,
	input  logic dn_ready,
	output wgt_t dn_data
);

	logic valid_s1;
	wgt_t data_s1;
	wgt_t nxt;

	always_comb begin
		nxt.cb = {base.b, base.g, base.r};
		nxt.co = {over.b, over.g, over.r};
		nxt.ao = over.a;
		nxt.w  = 16'(base.a) * 16'(FULL_ALPHA - over.a);
		nxt.v  = 16'(over.a) * 16'(FULL_ALPHA);
		// 255*Ab + Ao*(255-Ab); opaque base gives 65025, i.e. plain /255
		nxt.d  = 16'(base.a) * 16'(FULL_ALPHA) + 16'(over.a) * 16'(FULL_ALPHA - base.a);
		if (base == '0) begin
			nxt.path = PATH_PASS;
		end else if (base.a == FULL_ALPHA) begin
			nxt.path = PATH_OPAQUE;
		end else begin
			nxt.path = PATH_TRANS;
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

/* rtl/aob_mac.sv */
// ============================================================================
// aob_mac
// Stage 2: per-channel numerators and the blended alpha.
// ============================================================================
module aob_mac import aob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  wgt_t up_data,
	output logic dn_valid,
	input  logic dn_ready,
	output div_t dn_data
);

	logic valid_s2;
	div_t data_s2;
	div_t nxt;
	logic [16:0] asum;

	always_comb begin
		nxt.co   = up_data.co;
		nxt.ao   = up_data.ao;
		nxt.path = up_data.path;
		nxt.dz   = (up_data.d == '0);
		nxt.ds   = DS_W'(up_data.d) << DS_SH;
		nxt.quo  = '0;
		for (int i = 0; i < 3; i++) begin
			nxt.rem[i] = NUM_W'(up_data.cb[i]) * NUM_W'(up_data.w)
			           + NUM_W'(up_data.co[i]) * NUM_W'(up_data.v);
		end
		// floor(d/255) for d <= 65025
		asum      = 17'(up_data.d) + 17'(up_data.d[15:8]) + 17'd1;
		nxt.alpha = asum[15:8];
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= nxt;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule

/* rtl/aob_div_step.sv */
// ============================================================================
// aob_div_step
// One divider stage: two restoring quotient bits for each color lane.
// ============================================================================
module aob_div_step import aob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  div_t up_data,
	output logic dn_valid,
	input  logic dn_ready,
	output div_t dn_data
);

	// stages s3..s6 are copies of this one
	logic valid_s3;
	div_t data_s3;
	div_t nxt;
	logic [NUM_W-1:0] dhi;
	logic [NUM_W-1:0] dlo;
	logic [NUM_W-1:0] r1;
	logic             q1;
	logic             q0;

	always_comb begin
		nxt = up_data;
		dhi = NUM_W'({up_data.ds, 1'b0});
		dlo = NUM_W'(up_data.ds);
		r1  = '0;
		q1  = 1'b0;
		q0  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			q1 = (up_data.rem[i] >= dhi);
			r1 = q1 ? up_data.rem[i] - dhi : up_data.rem[i];
			q0 = (r1 >= dlo);
			nxt.rem[i] = q0 ? r1 - dlo : r1;
			nxt.quo[i] = {up_data.quo[i][5:0], q1, q0};
		end
		nxt.ds = up_data.ds >> 2;
	end

	assign up_ready = !valid_s3 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s3 <= nxt;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_data  = data_s3;

endmodule

/* rtl/aob_out.sv */
// ============================================================================
// aob_out
// Final stage: picks pass-through, zero-divisor or quotient result.
// ============================================================================
module aob_out import aob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  div_t up_data,
	output logic dn_valid,
	input  logic dn_ready,
	output res_t dn_data
);

	logic valid_s7;
	res_t data_s7;
	res_t nxt;

	always_comb begin
		nxt.path = up_data.path;
		if (up_data.path == PATH_PASS) begin
			nxt.alpha = up_data.ao;
			nxt.c     = up_data.co;
		end else begin
			nxt.alpha = up_data.alpha;
			nxt.c     = up_data.dz ? '0 : up_data.quo;
		end
	end

	assign up_ready = !valid_s7 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (up_ready) begin
			valid_s7 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s7 <= nxt;
		end
	end

	assign dn_valid = valid_s7;
	assign dn_data  = data_s7;

endmodule

/* rtl/aob_checker.sv */
// ============================================================================
// aob_checker
// Port-level checks for argb_over_blend, attached by bind.
// ============================================================================
module aob_checker import aob_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_alpha,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [1:0] blend_path
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_alpha) && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue) && $stable(blend_path))
		else $error("output changed during stall");

	// a free output register lets the whole chain move
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with a free output stage");

	a_path_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> blend_path == PATH_PASS || blend_path == PATH_TRANS
			|| blend_path == PATH_OPAQUE)
		else $error("undefined blend_path");

	a_opaque_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blend_path == PATH_OPAQUE |-> out_alpha == FULL_ALPHA)
		else $error("opaque base without full alpha");

	// zero alpha in the translucent path only when the divisor is zero
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blend_path == PATH_TRANS && out_alpha == 8'd0
			|-> out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
		else $error("nonzero color with zero blended alpha");

endmodule

bind argb_over_blend aob_checker u_aob_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_alpha  (out_alpha),
	.out_red    (out_red),
	.out_green  (out_green),
	.out_blue   (out_blue),
	.blend_path (blend_path)
);
